// ===== rtl/mld2q_pkg.sv =====
// ============================================================================
// mld2q_pkg
// Shared types and constants for the two-user QPSK ML detector.
// ============================================================================
package mld2q_pkg;

   localparam int RX_W      = 16;  // Q4.11 sample
   localparam int GAIN_W    = 16;  // Q2.13 gain
   localparam int IMG_W     = 19;  // sum of four signed gains
   localparam int DIFF_W    = 20;  // scaled sample minus image
   localparam int SQ_W      = 37;  // one square
   localparam int DIST_W    = 39;  // sum of four squares
   localparam int CAND_W    = 4;
   localparam int NUM_CAND  = 16;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_A11_RE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A11_IM = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_A12_RE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A12_IM = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A21_RE = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A21_IM = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_A22_RE = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_A22_IM = 4'd7;

   localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 16'sd8192;

   typedef struct packed {
      logic signed [RX_W-1:0] rx1_re;
      logic signed [RX_W-1:0] rx1_im;
      logic signed [RX_W-1:0] rx2_re;
      logic signed [RX_W-1:0] rx2_im;
   } req_type;

   typedef struct packed {
      logic user1_bit_i;
      logic user1_bit_q;
      logic user2_bit_i;
      logic user2_bit_q;
   } rsp_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] a11_re;
      logic signed [GAIN_W-1:0] a11_im;
      logic signed [GAIN_W-1:0] a12_re;
      logic signed [GAIN_W-1:0] a12_im;
      logic signed [GAIN_W-1:0] a21_re;
      logic signed [GAIN_W-1:0] a21_im;
      logic signed [GAIN_W-1:0] a22_re;
      logic signed [GAIN_W-1:0] a22_im;
   } gain_type;

   // word handed from cell to cell: sample plus best candidate so far
   typedef struct packed {
      logic                valid;
      req_type             rx;
      logic [DIST_W-1:0]   best;
      logic [CAND_W-1:0]   k;
   } chain_type;

endpackage

// ===== rtl/ml_detect_two_user_qpsk_top.sv =====
// ============================================================================
// ml_detect_two_user_qpsk_top
// Two-user QPSK maximum-likelihood detector over a 2x2 complex channel.
// ============================================================================
// One word in, one word out, at a sustained rate of one word per clock while req_stall is low. Each
// received word (two antenna samples, Q4.11) runs down a row of 16 cells, one
// per joint QPSK candidate; each cell holds its candidate's channel image,
// squares the four differences, sums them and keeps the smaller of its own
// distance and the best handed on by the cell before. The row is 3 stages
// per cell; a decision leaves the last cell and passes into the output
// register, or into the skid entry while the output is stalled.
// Ties go to the lower candidate index. The four gains (Q2.13, reset to the
// identity matrix) are written through the csr port, index 0..7 in the
// order a11_re, a11_im, a12_re, a12_im, a21_re, a21_im, a22_re, a22_im;
// other indices are ignored. Write gains only with no word in flight; a word
// may follow in the very next cycle and already sees the new gains.
// req_stall rises only when a result is stalled and a second one is ready
// behind it in the skid entry.
// ============================================================================
module ml_detect_two_user_qpsk_top
   import mld2q_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // sample words
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // decisions
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // gain writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_data
);

   // -- channel gains --------------------------------------------------------
   // gain_in is the value after this edge, reset included; the cells build
   // their candidate images from it so the images track gain_ff exactly
   gain_type gain_ff, gain_in;

   always_comb begin
      gain_in = gain_ff;
      if (reset) begin
         gain_in        = '0;
         gain_in.a11_re = GAIN_UNITY;
         gain_in.a22_re = GAIN_UNITY;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_A11_RE: gain_in.a11_re = csr_data;
            REG_A11_IM: gain_in.a11_im = csr_data;
            REG_A12_RE: gain_in.a12_re = csr_data;
            REG_A12_IM: gain_in.a12_im = csr_data;
            REG_A21_RE: gain_in.a21_re = csr_data;
            REG_A21_IM: gain_in.a21_im = csr_data;
            REG_A22_RE: gain_in.a22_re = csr_data;
            REG_A22_IM: gain_in.a22_im = csr_data;
            default:    gain_in = gain_ff;   // out of range: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
   end

   assign csr_ready = 1'b1;

   // -- cell row -------------------------------------------------------------
   // whole row advances together; it freezes only while the skid is full
   logic      enable;
   logic      skid_full;
   chain_type link [NUM_CAND+1];

   assign enable    = !skid_full;
   assign req_stall = skid_full;

   always_comb begin
      link[0].valid = req_valid && enable;
      link[0].rx    = req_data;
      link[0].best  = '0;   // ignored by the first cell
      link[0].k     = '0;
   end

   for (genvar g = 0; g < NUM_CAND; g++) begin : g_cell
      mld2q_cell #(
         .K (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .gain     (gain_in),
         .link_in  (link[g]),
         .link_out (link[g+1])
      );
   end

   // -- decision bits out ----------------------------------------------------
   logic    row_valid;
   rsp_type row_data;

   always_comb begin
      row_valid            = link[NUM_CAND].valid && enable;
      row_data.user1_bit_i = link[NUM_CAND].k[3];
      row_data.user1_bit_q = link[NUM_CAND].k[2];
      row_data.user2_bit_i = link[NUM_CAND].k[1];
      row_data.user2_bit_q = link[NUM_CAND].k[0];
   end

   mld2q_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid),
      .in_data   (row_data),
      .full      (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/mld2q_cell.sv =====
// ============================================================================
// mld2q_cell
// One candidate of the search: distance of its fixed QPSK pair to the
// sample, compared against the running best. Three register stages.
// ============================================================================
module mld2q_cell
   import mld2q_pkg::*;
#(
   parameter int K = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  gain_type  gain,
   input  chain_type link_in,
   output chain_type link_out
);

   localparam logic [CAND_W-1:0] CAND  = CAND_W'(K);
   localparam logic              FIRST = (K == 0);

   typedef struct packed {
      logic signed [IMG_W-1:0] t1r;
      logic signed [IMG_W-1:0] t1i;
      logic signed [IMG_W-1:0] t2r;
      logic signed [IMG_W-1:0] t2i;
   } img_type;

   function automatic logic signed [IMG_W-1:0] gterm(logic signed [GAIN_W-1:0] g,
                                                     logic pos);
      logic signed [IMG_W-1:0] e;
      e = IMG_W'(g);
      return pos ? e : -e;
   endfunction

   function automatic logic signed [DIFF_W-1:0] scale(logic signed [RX_W-1:0] r);
      logic signed [RX_W+1:0] s;
      s = {r, 2'b00};
      return DIFF_W'(s);
   endfunction

   function automatic logic [SQ_W-1:0] sqr(logic signed [RX_W-1:0] r,
                                           logic signed [IMG_W-1:0] t);
      logic signed [DIFF_W-1:0]   d;
      logic signed [2*DIFF_W-1:0] p;
      d = scale(r) - DIFF_W'(t);
      p = d * d;
      return p[SQ_W-1:0];
   endfunction

   // candidate image, held in a register (the user must change gains only while idle; the cell does not enforce it)
   img_type img_ff, img_in;

   always_comb begin
      img_in.t1r = gterm(gain.a11_re, CAND[3])  + gterm(gain.a11_im, ~CAND[2])
                 + gterm(gain.a12_re, CAND[1])  + gterm(gain.a12_im, ~CAND[0]);
      img_in.t1i = gterm(gain.a11_re, CAND[2])  + gterm(gain.a11_im, CAND[3])
                 + gterm(gain.a12_re, CAND[0])  + gterm(gain.a12_im, CAND[1]);
      img_in.t2r = gterm(gain.a21_re, CAND[3])  + gterm(gain.a21_im, ~CAND[2])
                 + gterm(gain.a22_re, CAND[1])  + gterm(gain.a22_im, ~CAND[0]);
      img_in.t2i = gterm(gain.a21_re, CAND[2])  + gterm(gain.a21_im, CAND[3])
                 + gterm(gain.a22_re, CAND[0])  + gterm(gain.a22_im, CAND[1]);
   end

   always_ff @(posedge clock) begin
      img_ff <= img_in;
   end

   // stage A: squares
   chain_type       a_word_ff;
   logic [SQ_W-1:0] a_sq_ff [4];
   logic [SQ_W-1:0] a_sq_in [4];
   // stage B: pair sums
   chain_type       b_word_ff;
   logic [SQ_W:0]   b_sum_ff [2];
   logic [SQ_W:0]   b_sum_in [2];
   // stage C: total and select
   chain_type       c_word_ff, c_word_in;
   logic [DIST_W-1:0] total;

   always_comb begin
      a_sq_in[0] = sqr(link_in.rx.rx1_re, img_ff.t1r);
      a_sq_in[1] = sqr(link_in.rx.rx1_im, img_ff.t1i);
      a_sq_in[2] = sqr(link_in.rx.rx2_re, img_ff.t2r);
      a_sq_in[3] = sqr(link_in.rx.rx2_im, img_ff.t2i);
      b_sum_in[0] = {1'b0, a_sq_ff[0]} + {1'b0, a_sq_ff[1]};
      b_sum_in[1] = {1'b0, a_sq_ff[2]} + {1'b0, a_sq_ff[3]};
      total = {1'b0, b_sum_ff[0]} + {1'b0, b_sum_ff[1]};
      c_word_in = b_word_ff;
      // strict compare: a tie keeps the lower index
      if (FIRST || (total < b_word_ff.best)) begin
         c_word_in.best = total;
         c_word_in.k    = CAND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_word_ff.valid <= 1'b0;
         b_word_ff.valid <= 1'b0;
         c_word_ff.valid <= 1'b0;
      end else if (enable) begin
         a_word_ff.valid <= link_in.valid;
         b_word_ff.valid <= a_word_ff.valid;
         c_word_ff.valid <= c_word_in.valid;
      end
      if (enable) begin
         a_word_ff.rx   <= link_in.rx;
         a_word_ff.best <= link_in.best;
         a_word_ff.k    <= link_in.k;
         a_sq_ff        <= a_sq_in;
         b_word_ff.rx   <= a_word_ff.rx;
         b_word_ff.best <= a_word_ff.best;
         b_word_ff.k    <= a_word_ff.k;
         b_sum_ff       <= b_sum_in;
         c_word_ff.rx   <= c_word_in.rx;
         c_word_ff.best <= c_word_in.best;
         c_word_ff.k    <= c_word_in.k;
      end
   end

   assign link_out = c_word_ff;

endmodule

// ===== rtl/mld2q_skid.sv =====
// ============================================================================
// mld2q_skid
// Output register plus one skid entry; full skid freezes the cell row.
// ============================================================================
module mld2q_skid
   import mld2q_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = in_valid;
            rsp_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/mld2q_checker.sv =====
// ============================================================================
// mld2q_checker
// Port-level checks on the detector, bound to the top level.
// ============================================================================
module mld2q_checker
   import mld2q_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input req_type              req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [GAIN_W-1:0]    csr_data
);

   // reset leaves no result and no back-pressure
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // input is held off only while a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   // back-pressure starts only after the result side was stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without output stall");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

endmodule

bind ml_detect_two_user_qpsk_top mld2q_checker u_checker (.*);
